@@ rtl/core/uvst_pkg.sv @@
// ---------------------------------------------------------------------------
// uvst_pkg: shared types and constants of the unique value set table
// Capacity, field widths, command and status codes, controller states and
// the control bundle that the table drives into each storage cell.
// ---------------------------------------------------------------------------
package uvst_pkg;

    // Table geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 5;
    localparam int STAT_W   = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_DUP    = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_ABSENT = 2'd3;

    // Position reported for an absent value
    localparam logic signed [POS_W-1:0] POS_NONE = '1;

    // Controller states
    typedef enum logic
    {
        FSM_IDLE,
        FSM_EXEC
    } fsm_state_t;

    // Per-cell control bundle
    typedef struct packed
    {
        logic active;     // cell index lies below the current count
        logic load_new;   // cell takes the key (append)
        logic remove_en;  // a remove commits this cycle
    } cell_ctrl_t;

endpackage

@@ rtl/core/uvst_in_if.sv @@
// ---------------------------------------------------------------------------
// uvst_in_if: command channel of the unique value set table
// Valid/ready channel carrying one command and its signed value.
// ---------------------------------------------------------------------------
interface uvst_in_if
    import uvst_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [VAL_W-1:0]  value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

@@ rtl/core/uvst_out_if.sv @@
// ---------------------------------------------------------------------------
// uvst_out_if: result channel of the unique value set table
// Valid/ready channel carrying found flag, position, count and status.
// ---------------------------------------------------------------------------
interface uvst_out_if
    import uvst_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     found;
    logic signed [POS_W-1:0]  position;
    logic [POS_W-1:0]         entry_count;
    logic [STAT_W-1:0]        status;

    modport source (output valid, output found, output position,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input found, input position,
                    input entry_count, input status, output ready);
endinterface

@@ rtl/core/uvst_cell.sv @@
// ---------------------------------------------------------------------------
// uvst_cell: one storage cell of the value table
// Holds one entry, compares it against the search key and either appends
// the key or takes its upper neighbor's entry when a remove closes a gap.
// ---------------------------------------------------------------------------
module uvst_cell
    import uvst_pkg::*;
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic signed [VAL_W-1:0]  key,
    input  logic signed [VAL_W-1:0]  upper_value,
    input  logic                     seen_in,
    output logic                     seen_out,
    output logic                     match,
    output logic signed [VAL_W-1:0]  value
);

    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;

    // Compare only live entries; carry the "match at or below" flag upward
    assign match    = ctrl.active && (value_reg == key);
    assign seen_out = seen_in | match;
    assign value    = value_reg;

    // Append the key, or shift down from the neighbor at and above the hit
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load_new)
        begin
            value_next = key;
        end
        else if (ctrl.remove_en && seen_out)
        begin
            value_next = upper_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

@@ rtl/core/unique_value_set_table.sv @@
// ---------------------------------------------------------------------------
// unique_value_set_table: packed set of distinct signed 32-bit values
// Keeps values in insertion order; lookup, insert and remove with
// compaction, one result transaction per command transaction.
// ---------------------------------------------------------------------------
// Usage:
//   item   : command transaction (cmd, value), valid/ready.
//   result : result transaction (found, position, entry_count, status).
//   Each command is registered when taken in the idle state; in the
//   execute state every cell compares in parallel, the position is
//   encoded and the cells append or shift down by one. Commands are
//   taken only in the idle state, so no new one is accepted before the
//   last has executed; the compare plus match-prefix chain through the
//   row of cells is evaluated in the execute state. The output register
//   loads when the command commits, which waits until it is free. A new
//   command is taken while that result still waits; if the receiver
//   stalls, the second command holds in its execute state until the
//   output register frees, and no further command is accepted meanwhile.
//   Reset clears the count (empty table) and the control state; cell
//   contents are not cleared, as only entries below the count are read.
// ---------------------------------------------------------------------------
module unique_value_set_table
    import uvst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    uvst_in_if.sink    item,
    uvst_out_if.source result
);

    fsm_state_t               state_reg;
    fsm_state_t               state_next;
    logic [CMD_W-1:0]         cmd_reg;
    logic signed [VAL_W-1:0]  key_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     found_reg;
    logic signed [POS_W-1:0]  position_reg;
    logic [POS_W-1:0]         entry_count_reg;
    logic [STAT_W-1:0]        status_reg;

    cell_ctrl_t               cell_ctrl [CAPACITY];
    logic [CAPACITY-1:0]      match;
    logic [CAPACITY:0]        seen;
    logic signed [VAL_W-1:0]  cell_value [CAPACITY];

    logic                     commit;
    logic                     found;
    logic [IDX_W-1:0]         hit_idx;
    logic                     insert_ok;
    logic                     remove_ok;
    logic                     is_full;
    logic signed [POS_W-1:0]  position_next;
    logic [STAT_W-1:0]        status_next;

    // Row of cells; each hands its entry down to the cell below
    assign seen[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign cell_ctrl[i].active    = (CNT_W'(i) < count_reg);
        assign cell_ctrl[i].load_new  = commit && insert_ok &&
                                        (count_reg == CNT_W'(i));
        assign cell_ctrl[i].remove_en = commit && remove_ok;

        uvst_cell u_cell
        (
            .clk         (clk),
            .ctrl        (cell_ctrl[i]),
            .key         (key_reg),
            .upper_value (cell_value[(i + 1 < CAPACITY) ? i + 1 : i]),
            .seen_in     (seen[i]),
            .seen_out    (seen[i+1]),
            .match       (match[i]),
            .value       (cell_value[i])
        );
    end

    // Encode the single hit into an index
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign found   = seen[CAPACITY];
    assign is_full = (count_reg >= CNT_W'(CAPACITY));

    // Decode the command into result fields and state changes
    always_comb
    begin
        insert_ok     = 1'b0;
        remove_ok     = 1'b0;
        position_next = found ? POS_W'(hit_idx) : POS_NONE;
        status_next   = STATUS_OK;
        count_next    = count_reg;
        unique case (cmd_reg)
            CMD_INSERT:
            begin
                if (found)
                begin
                    status_next = STATUS_DUP;
                end
                else if (is_full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    insert_ok     = 1'b1;
                    position_next = POS_W'(count_reg);
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (!found)
                begin
                    status_next = STATUS_ABSENT;
                end
                else
                begin
                    remove_ok  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                // lookup, and the unused code, change nothing
            end
        endcase
    end

    // Controller: take a transaction, then execute once the output frees
    assign commit     = (state_reg == FSM_EXEC) && (!out_valid_reg || result.ready);
    assign item.ready = (state_reg == FSM_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (commit)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Capture the command and hold the result payload
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            cmd_reg <= item.cmd;
            key_reg <= item.value;
        end
        if (commit)
        begin
            found_reg       <= found;
            position_reg    <= position_next;
            entry_count_reg <= POS_W'(count_next);
            status_reg      <= status_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.found       = found_reg;
    assign result.position    = position_reg;
    assign result.entry_count = entry_count_reg;
    assign result.status      = status_reg;

    // Live entries are distinct, so at most one cell hits
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_EXEC) |-> $onehot0(match))
        else $error("more than one cell matched the key");

    // Count never exceeds capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // An accepted insert grows the table by exactly one
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && insert_ok) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance the count");

    // A command that finds nothing to do leaves the count alone
    a_noop_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !insert_ok && !remove_ok) |=> $stable(count_reg))
        else $error("count changed on a command without effect");

endmodule

@@ sim/tb_unique_value_set_table.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_unique_value_set_table: self-checking bench for the unique value set table
// Sends lookup, insert, remove and unused-code commands with random gaps, takes results
// with random stalls, and checks each result transaction against a
// predicted copy of the ordered set that is updated on every accepted command.
// ---------------------------------------------------------------------------
module tb_unique_value_set_table
    import uvst_pkg::*;
();

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int MAX_GAP        = 14;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int REPORT_LIMIT   = 10;

    // Command code the block does not define; it behaves as a lookup
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed
    {
        logic              found;
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  entry_count;
        logic [STAT_W-1:0] status;
    } set_result_t;

    typedef struct
    {
        logic [CMD_W-1:0] op;
        logic [VAL_W-1:0] key;
    } set_command_t;

    logic clk;
    logic rst_n = 1'b0;

    // Local copies of the driven signals, known from time zero
    logic             drv_valid = 1'b0;
    logic [CMD_W-1:0] drv_cmd   = CMD_LOOKUP;
    logic [VAL_W-1:0] drv_value = '0;
    logic             rcv_ready = 1'b0;

    uvst_in_if  in_bus ();
    uvst_out_if out_bus ();

    assign in_bus.valid  = drv_valid;
    assign in_bus.cmd    = drv_cmd;
    assign in_bus.value  = drv_value;
    assign out_bus.ready = rcv_ready;

    unique_value_set_table DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_bus),
        .result (out_bus)
    );

    // Predicted table contents
    logic [VAL_W-1:0] set_values [CAPACITY];
    int               set_count = 0;

    set_command_t pending_commands [$];
    set_result_t  expected_results [$];
    int           error_count = 0;
    int           cycle_count = 0;

    // Clock
    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // Apply one command to the predicted table and return its result
    function automatic set_result_t apply_command(logic [CMD_W-1:0] op,
                                                  logic [VAL_W-1:0] key);
        set_result_t r;
        int          hit;
        hit = -1;
        for (int i = 0; i < set_count; i++)
        begin
            if (hit < 0 && set_values[i] == key)
                hit = i;
        end
        r.found    = (hit >= 0);
        r.position = r.found ? POS_W'(hit) : POS_NONE;
        r.status   = STATUS_OK;
        if (op == CMD_INSERT)
        begin
            if (r.found)
                r.status = STATUS_DUP;
            else if (set_count >= CAPACITY)
                r.status = STATUS_FULL;
            else
            begin
                set_values[set_count] = key;
                r.position            = POS_W'(set_count);
                set_count++;
            end
        end
        else if (op == CMD_REMOVE)
        begin
            if (!r.found)
                r.status = STATUS_ABSENT;
            else
            begin
                // close the gap, keep order
                for (int i = hit; i + 1 < set_count; i++)
                    set_values[i] = set_values[i + 1];
                set_count--;
            end
        end
        r.entry_count = POS_W'(set_count);
        return r;
    endfunction

    function automatic void report_error(string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    task automatic add_command(logic [CMD_W-1:0] op, logic [VAL_W-1:0] key);
        set_command_t c;
        c.op  = op;
        c.key = key;
        pending_commands.push_back(c);
    endtask

    // Random value: full range, small signed, or an extreme
    function automatic logic [VAL_W-1:0] random_key();
        logic [VAL_W-1:0] k;
        case ($urandom_range(0, 3))
            0:       k = VAL_W'($signed($urandom_range(0, 15)) - 8);
            1:       k = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: k = $urandom;
        endcase
        return k;
    endfunction

    // Command driver: present queued transactions with random gaps
    int send_gap   = 0;
    bit send_burst = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        set_command_t next_cmd;
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            // predict on accept
            if (drv_valid && in_bus.ready)
                expected_results.push_back(apply_command(drv_cmd, drv_value));
            if (!drv_valid || in_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    drv_valid <= 1'b0;
                end
                else if (pending_commands.size() > 0)
                begin
                    next_cmd = pending_commands.pop_front();
                    drv_valid <= 1'b1;
                    drv_cmd   <= next_cmd.op;
                    drv_value <= next_cmd.key;
                    if ($urandom_range(0, 63) == 0)
                        send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
                end
                else
                    drv_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check each transaction, stall at random
    int hold_left  = 0;
    bit take_burst = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        set_result_t want;
        if (!rst_n)
        begin
            rcv_ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_bus.valid && rcv_ready)
            begin
                if (expected_results.size() == 0)
                    report_error("result transaction with no command pending");
                else
                begin
                    want = expected_results.pop_front();
                    if (out_bus.found !== want.found)
                        report_error($sformatf("found: expected %0d, got %0d",
                                               want.found, out_bus.found));
                    if (out_bus.position !== want.position)
                        report_error($sformatf("position: expected %0d, got %0d",
                                               $signed(want.position),
                                               out_bus.position));
                    if (out_bus.entry_count !== want.entry_count)
                        report_error($sformatf("entry_count: expected %0d, got %0d",
                                               want.entry_count,
                                               out_bus.entry_count));
                    if (out_bus.status !== want.status)
                        report_error($sformatf("status: expected %0d, got %0d",
                                               want.status, out_bus.status));
                end
                if ($urandom_range(0, 63) == 0)
                    take_burst = !take_burst;
                hold_left = take_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rcv_ready <= 1'b0;
            end
            else
                rcv_ready <= 1'b1;
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [VAL_W-1:0] key_pool [$];
        logic [VAL_W-1:0] key;
        int               pool_size;
        int               ops;
        int               roll;
        int               directed_count;
        bit               fill_phase;

        // Directed: empty table, extremes, fill to capacity, full and
        // duplicate inserts, unused code, removes at first/middle/last
        add_command(CMD_LOOKUP, 32'h0000_0000);
        add_command(CMD_INSERT, 32'h8000_0000);
        add_command(CMD_INSERT, 32'h7FFF_FFFF);
        add_command(CMD_INSERT, 32'h0000_0000);
        add_command(CMD_INSERT, 32'hFFFF_FFFF);
        for (int k = 0; k < CAPACITY - 4; k++)
            add_command(CMD_INSERT, 32'h1 << k);
        add_command(CMD_INSERT, 32'd77);
        add_command(CMD_INSERT, 32'h7FFF_FFFF);
        add_command(CMD_UNUSED, 32'h0000_0400);
        add_command(CMD_REMOVE, 32'h0000_0000);
        add_command(CMD_REMOVE, 32'h8000_0000);
        add_command(CMD_REMOVE, 32'h0000_0800);
        add_command(CMD_REMOVE, 32'd99);
        add_command(CMD_LOOKUP, 32'h7FFF_FFFF);
        directed_count = pending_commands.size();

        // Random: alternate fill-leaning and drain-leaning phases over a pool
        fill_phase = 1'b1;
        while (pending_commands.size() < directed_count + RANDOM_ITEMS)
        begin
            pool_size = $urandom_range(1, CAPACITY + 8);
            key_pool.delete();
            for (int k = 0; k < pool_size; k++)
                key_pool.push_back(random_key());
            ops = $urandom_range(20, 80);
            for (int n = 0; n < ops; n++)
            begin
                roll = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0)
                    key = random_key();
                else
                    key = key_pool[$urandom_range(0, pool_size - 1)];
                if (roll < (fill_phase ? 55 : 25))
                    add_command(CMD_INSERT, key);
                else if (roll < (fill_phase ? 75 : 70))
                    add_command(CMD_REMOVE, key);
                else if (roll < 95)
                    add_command(CMD_LOOKUP, key);
                else
                    add_command(CMD_UNUSED, key);
            end
            fill_phase = !fill_phase;
        end

        // Hold reset, release away from the rising edge
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every command to go out and every result to return
        while (pending_commands.size() != 0 || drv_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_error("results still outstanding at end of run");

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/uvst_pkg.sv
rtl/core/uvst_in_if.sv
rtl/core/uvst_out_if.sv
rtl/core/uvst_cell.sv
rtl/core/unique_value_set_table.sv
sim/tb_unique_value_set_table.sv
